### rtl/core/sha256_byte_stream_hasher_defines.svh
// Assertion macros for the SHA-256 byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
// implication checked every clock, off during reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/core/sha256_pkg.sv
// Package: SHA-256 round constants, initial hash, rotate helper and shared types
`timescale 1ns / 1ps
package sha256_pkg;
	localparam int BlockBytes = 64;
	localparam int Rounds = 64;
	localparam int DigestWords = 8;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic load_init;   // reload initial hash
		logic wr_byte;     // write byte into block buffer
		logic [5:0] wr_addr;
		logic [7:0] wr_data;
		logic start;       // begin compression of the buffer
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
	} dp_sts_t;

	function automatic word_t k_const(input logic [5:0] t);
		word_t k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t h_init(input logic [2:0] i);
		word_t h;
		case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic word_t rotr(input word_t v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction
endpackage

### rtl/core/sha256_byte_stream_hasher.sv
// Top level: SHA-256 hasher taking at most one message byte per beat
//  channel | dir | beat payload                         | handshake
//  in      | in  | byte_value, has_byte, last           | in_valid / in_ready
//  out     | out | digest_word, word_index, last_word   | out_valid / out_ready
// A byte is taken while idle; a full block starts its compression and holds off input.
// Closing writes one pad byte per cycle from the fill point to byte 63 (all 64
// for a fresh block), then a compression, twice if the pad spills;
// then eight digest beats. The compression loop sets the rate.
// arst_n resets the control state and reloads the initial hash.
// Output stalls hold the digest word; input is not taken until it drains.
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_defines.svh"
module sha256_byte_stream_hasher (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] byte_value,
	input  logic has_byte,
	input  logic last,
	output logic out_valid,
	input  logic out_ready,
	output logic [31:0] digest_word,
	output logic [2:0] word_index,
	output logic last_word
);
	sha256_pkg::dp_cmd_t cmd;
	sha256_pkg::dp_sts_t sts;

	sha256_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.byte_value(byte_value), .has_byte(has_byte), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.word_index(word_index), .last_word(last_word),
		.cmd(cmd), .sts(sts)
	);

	sha256_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .sts(sts),
		.rd_idx(word_index), .rd_word(digest_word)
	);

	`SHA_ASSERT_IMP(a_no_out_busy, clk, arst_n, out_valid, !sts.busy, "digest shown while busy")
	`SHA_ASSERT_IMP(a_no_in_out, clk, arst_n, out_valid, !in_ready, "input open during output")
	`SHA_ASSERT_NEXT(a_start_busy, clk, arst_n, cmd.start, sts.busy, "start did not raise busy")
endmodule

### rtl/core/sha256_dp.sv
// Datapath: message window, schedule and one-round-per-cycle compression
`timescale 1ns / 1ps
module sha256_dp (
	input  logic clk,
	input  logic arst_n,
	input  sha256_pkg::dp_cmd_t cmd,
	output sha256_pkg::dp_sts_t sts,
	input  logic [2:0] rd_idx,
	output sha256_pkg::word_t rd_word
);
	sha256_pkg::word_t w_q [16];
	sha256_pkg::word_t h_q [8];
	sha256_pkg::word_t a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0] rnd_q;
	logic busy_q;
	logic fin_q;

	sha256_pkg::word_t w_new, w_cur, s0, s1, t1, t2, ep0, ep1, ch, maj;
	logic [5:0] t;

	assign t = rnd_q;
	assign sts.busy = busy_q | fin_q;
	assign rd_word = h_q[rd_idx];

	always_comb begin
		s0 = sha256_pkg::rotr(w_q[1], 7) ^ sha256_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha256_pkg::rotr(w_q[14], 17) ^ sha256_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		w_cur = (t < 6'd16) ? w_q[0] : w_new;
		ep1 = sha256_pkg::rotr(e_q, 6) ^ sha256_pkg::rotr(e_q, 11) ^ sha256_pkg::rotr(e_q, 25);
		ch = (e_q & f_q) ^ (~e_q & g_q);
		t1 = hh_q + ep1 + ch + sha256_pkg::k_const(t) + w_cur;
		ep0 = sha256_pkg::rotr(a_q, 2) ^ sha256_pkg::rotr(a_q, 13) ^ sha256_pkg::rotr(a_q, 22);
		maj = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
		t2 = ep0 + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			rnd_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::h_init(3'(i));
		end else begin
			fin_q <= 1'b0;
			if (cmd.load_init) begin
				for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::h_init(3'(i));
			end
			if (cmd.start) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (t == 6'd63) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (fin_q) begin
				h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
				h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
			end
		end
	end

	// bytes land big-endian in the schedule window while idle
	always_ff @(posedge clk) begin
		if (busy_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_cur;
			hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end else begin
			if (cmd.wr_byte)
				w_q[cmd.wr_addr[5:2]][{~cmd.wr_addr[1:0], 3'b000} +: 8] <= cmd.wr_data;
			if (cmd.start) begin
				a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
				e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
			end
		end
	end
endmodule

### rtl/core/sha256_ctrl.sv
// Controller: byte intake, padding, compression sequencing and digest output
`timescale 1ns / 1ps
module sha256_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] byte_value,
	input  logic has_byte,
	input  logic last,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] word_index,
	output logic last_word,
	output sha256_pkg::dp_cmd_t cmd,
	input  sha256_pkg::dp_sts_t sts
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WAIT = 3'd1; // compress full block, then maybe close
	localparam logic [2:0] S_PAD  = 3'd2; // write padding bytes
	localparam logic [2:0] S_PWT  = 3'd3; // compress padded block
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [6:0] fill_q;
	logic [60:0] total_q;
	logic close_q;
	logic len_done_q; // length goes in the current pad block
	logic [6:0] pos_q;
	logic [2:0] idx_q;
	logic [6:0] fill_nx;
	logic [63:0] bits;
	logic [5:0] lb;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign word_index = idx_q;
	assign last_word = (idx_q == 3'd7);
	assign bits = {total_q, 3'b000};
	assign fill_nx = fill_q + 7'd1;
	assign lb = 6'(7'd63 - pos_q);

	always_comb begin
		cmd = '0;
		if (state_q == S_IDLE && in_valid && has_byte) begin
			cmd.wr_byte = 1'b1;
			cmd.wr_addr = fill_q[5:0];
			cmd.wr_data = byte_value;
			cmd.start = (fill_nx == 7'd64);
		end else if (state_q == S_PAD) begin
			cmd.wr_byte = 1'b1;
			cmd.wr_addr = pos_q[5:0];
			if (pos_q == fill_q) cmd.wr_data = 8'h80;
			else if (pos_q >= 7'd56 && len_done_q) cmd.wr_data = bits[8*lb +: 8];
			else cmd.wr_data = 8'h00;
			cmd.start = (pos_q == 7'd63);
		end
		cmd.load_init = (state_q == S_OUT) && out_ready && (idx_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			total_q <= '0;
			close_q <= 1'b0;
			len_done_q <= 1'b0;
			pos_q <= '0;
			idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						close_q <= last;
						if (has_byte) begin
							total_q <= total_q + 61'd1;
							fill_q <= (fill_nx == 7'd64) ? 7'd0 : fill_nx;
						end
						if (has_byte && fill_nx == 7'd64) begin
							state_q <= S_WAIT;
						end else if (last) begin
							state_q <= S_PAD;
							pos_q <= has_byte ? fill_nx : fill_q;
							fill_q <= has_byte ? fill_nx : fill_q;
							len_done_q <= ((has_byte ? fill_nx : fill_q) < 7'd56);
						end
					end
				end
				S_WAIT: begin
					if (!cmd.start && !sts.busy) begin
						if (close_q) begin
							state_q <= S_PAD;
							pos_q <= '0;
							len_done_q <= 1'b1;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PAD: begin
					pos_q <= pos_q + 7'd1;
					if (pos_q == 7'd63) state_q <= S_PWT;
				end
				S_PWT: begin
					if (!sts.busy && !cmd.start) begin
						if (len_done_q) begin
							state_q <= S_OUT;
							idx_q <= '0;
						end else begin
							// 0x80 went in the first block; second block is zeros + length
							state_q <= S_PAD;
							fill_q <= 7'd64;
							pos_q <= '0;
							len_done_q <= 1'b1;
						end
					end
				end
				S_OUT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q <= S_IDLE;
							fill_q <= '0;
							total_q <= '0;
							close_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
